[src/psd_pkg.sv]
// ----------------------------------------------------------------------------
// psd_pkg
// shared constants for the point to segment distance pipeline
// ----------------------------------------------------------------------------
package psd_pkg;

    // register stages through the split multiplier
    localparam int MUL_LAT = 2;

endpackage

[src/psd_in_if.sv]
// ----------------------------------------------------------------------------
// psd_in_if
// query channel: point and segment endpoints with valid/ready
// ----------------------------------------------------------------------------
interface psd_in_if #(
    parameter int COORD_WIDTH = 32
);
    logic                          valid;
    logic                          ready;
    logic signed [COORD_WIDTH-1:0] point_x;
    logic signed [COORD_WIDTH-1:0] point_y;
    logic signed [COORD_WIDTH-1:0] start_x;
    logic signed [COORD_WIDTH-1:0] start_y;
    logic signed [COORD_WIDTH-1:0] end_x;
    logic signed [COORD_WIDTH-1:0] end_y;

    modport source (
        output valid, point_x, point_y, start_x, start_y, end_x, end_y,
        input  ready
    );
    modport sink (
        input  valid, point_x, point_y, start_x, start_y, end_x, end_y,
        output ready
    );
endinterface

[src/psd_out_if.sv]
// ----------------------------------------------------------------------------
// psd_out_if
// result channel: floored distance with valid/ready
// ----------------------------------------------------------------------------
interface psd_out_if #(
    parameter int COORD_WIDTH = 32
);
    logic                 valid;
    logic                 ready;
    logic [COORD_WIDTH:0] distance;

    modport source (
        output valid, distance,
        input  ready
    );
    modport sink (
        input  valid, distance,
        output ready
    );
endinterface

[src/point_segment_distance.sv]
// ----------------------------------------------------------------------------
// point_segment_distance
// distance from a query point to a 2d segment, exact, floored to the grid
// ----------------------------------------------------------------------------
//  channel | dir | transaction payload
//  --------+-----+-------------------------------------------------------------
//  in_ch   | in  | point_x, point_y, start_x, start_y, end_x, end_y (signed)
//  out_ch  | out | distance (unsigned integer, one bit wider than a coordinate)
//
//  one query per cycle while the skid register is empty; each query passes
//  9 front-end stages, one divider stage per quotient bit (2*COORD_WIDTH+2),
//  one root stage per result bit (COORD_WIDTH+1) and the output register
//  rst_n clears only valid bits; payload registers are not reset
//  the whole pipe stalls only when the output skid register holds a
//  transaction; a result waiting at the output does not block intake
// ----------------------------------------------------------------------------
module point_segment_distance #(
    parameter int COORD_WIDTH = 32
) (
    input  logic      clk,
    input  logic      rst_n,
    psd_in_if.sink    in_ch,
    psd_out_if.source out_ch
);
    localparam int W    = COORD_WIDTH;
    localparam int D    = W + 1;          // coordinate difference / magnitude
    localparam int P    = 2 * D;          // product of two magnitudes
    localparam int SW   = P + 2;          // signed sum of two products
    localparam int CM   = P + 1;          // cross magnitude and squared length
    localparam int NW   = 2 * CM;         // numerator
    localparam int LW   = P + 1;          // denominator
    localparam int OUTW = W + 1;
    localparam int QW   = 2 * OUTW;       // squared distance
    localparam int ML   = psd_pkg::MUL_LAT;

    // global advance: held only while the skid register is occupied
    logic en;
    logic skid_valid_reg;
    assign en          = !skid_valid_reg;
    assign in_ch.ready = en;

    // ---------------- stage a: coordinate differences ----------------
    logic signed [D-1:0] ax_reg, ay_reg, cx_reg, cy_reg, bx_reg, by_reg;
    logic                va_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ax_reg <= D'(in_ch.point_x) - D'(in_ch.start_x);
            ay_reg <= D'(in_ch.point_y) - D'(in_ch.start_y);
            cx_reg <= D'(in_ch.end_x)   - D'(in_ch.start_x);
            cy_reg <= D'(in_ch.end_y)   - D'(in_ch.start_y);
            bx_reg <= D'(in_ch.point_x) - D'(in_ch.end_x);
            by_reg <= D'(in_ch.point_y) - D'(in_ch.end_y);
        end
    end

    // ---------------- stage b: magnitudes and signs ----------------
    logic [D-1:0] max_reg, may_reg, mcx_reg, mcy_reg, mbx_reg, mby_reg;
    logic [3:0]   sgn_b_reg;   // ax, ay, cx, cy signs
    logic         vb_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            max_reg   <= ax_reg[D-1] ? D'(-ax_reg) : D'(ax_reg);
            may_reg   <= ay_reg[D-1] ? D'(-ay_reg) : D'(ay_reg);
            mcx_reg   <= cx_reg[D-1] ? D'(-cx_reg) : D'(cx_reg);
            mcy_reg   <= cy_reg[D-1] ? D'(-cy_reg) : D'(cy_reg);
            mbx_reg   <= bx_reg[D-1] ? D'(-bx_reg) : D'(bx_reg);
            mby_reg   <= by_reg[D-1] ? D'(-by_reg) : D'(by_reg);
            sgn_b_reg <= {ax_reg[D-1], ay_reg[D-1], cx_reg[D-1], cy_reg[D-1]};
        end
    end

    // ---------------- multipliers: all ten products at once ----------------
    logic [P-1:0] p_dot0, p_dot1, p_cxx, p_cyy, p_axx, p_ayy, p_bxx, p_byy;
    logic [P-1:0] p_cr0, p_cr1;

    psd_mul #(.WIDTH(D)) u_mul_dot0 (.clk, .en, .a(max_reg), .b(mcx_reg), .p(p_dot0));
    psd_mul #(.WIDTH(D)) u_mul_dot1 (.clk, .en, .a(may_reg), .b(mcy_reg), .p(p_dot1));
    psd_mul #(.WIDTH(D)) u_mul_cxx  (.clk, .en, .a(mcx_reg), .b(mcx_reg), .p(p_cxx));
    psd_mul #(.WIDTH(D)) u_mul_cyy  (.clk, .en, .a(mcy_reg), .b(mcy_reg), .p(p_cyy));
    psd_mul #(.WIDTH(D)) u_mul_axx  (.clk, .en, .a(max_reg), .b(max_reg), .p(p_axx));
    psd_mul #(.WIDTH(D)) u_mul_ayy  (.clk, .en, .a(may_reg), .b(may_reg), .p(p_ayy));
    psd_mul #(.WIDTH(D)) u_mul_bxx  (.clk, .en, .a(mbx_reg), .b(mbx_reg), .p(p_bxx));
    psd_mul #(.WIDTH(D)) u_mul_byy  (.clk, .en, .a(mby_reg), .b(mby_reg), .p(p_byy));
    psd_mul #(.WIDTH(D)) u_mul_cr0  (.clk, .en, .a(max_reg), .b(mcy_reg), .p(p_cr0));
    psd_mul #(.WIDTH(D)) u_mul_cr1  (.clk, .en, .a(may_reg), .b(mcx_reg), .p(p_cr1));

    // signs and valid ride alongside the multiplier stages
    logic [3:0] sgn_dly_reg [ML];
    logic       vm_reg      [ML];

    genvar k;
    generate
        for (k = 0; k < ML; k++)
        begin : g_mdly
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    sgn_dly_reg[k] <= (k == 0) ? sgn_b_reg : sgn_dly_reg[(k == 0) ? 0 : k-1];
                end
            end
            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    vm_reg[k] <= 1'b0;
                end
                else if (en)
                begin
                    vm_reg[k] <= (k == 0) ? vb_reg : vm_reg[(k == 0) ? 0 : k-1];
                end
            end
        end
    endgenerate

    // ---------------- stage c: dot, length, cross, endpoint squares ----------------
    logic               s_ax, s_ay, s_cx, s_cy;
    logic signed [SW-1:0] t_dot0, t_dot1, t_cr0, t_cr1;
    logic signed [SW-1:0] dot_reg, cross_reg;
    logic [LW-1:0]        len_reg, sqa_reg, sqb_reg;
    logic                 vc_reg;

    assign {s_ax, s_ay, s_cx, s_cy} = sgn_dly_reg[ML-1];
    assign t_dot0 = SW'(p_dot0);
    assign t_dot1 = SW'(p_dot1);
    assign t_cr0  = SW'(p_cr0);
    assign t_cr1  = SW'(p_cr1);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dot_reg   <= ((s_ax ^ s_cx) ? -t_dot0 : t_dot0)
                       + ((s_ay ^ s_cy) ? -t_dot1 : t_dot1);
            // cross = ax*cy - ay*cx
            cross_reg <= ((s_ax ^ s_cy) ? -t_cr0 : t_cr0)
                       - ((s_ay ^ s_cx) ? -t_cr1 : t_cr1);
            len_reg   <= LW'(p_cxx) + LW'(p_cyy);
            sqa_reg   <= LW'(p_axx) + LW'(p_ayy);
            sqb_reg   <= LW'(p_bxx) + LW'(p_byy);
        end
    end

    // ---------------- stage d: classify the projection ----------------
    logic          near_start, near_end;
    logic [CM-1:0] crm_reg;
    logic [LW-1:0] sq_reg, lend_reg;
    logic          perp_reg;
    logic          vd_reg;

    // degenerate segment or projection before the start point
    assign near_start = (len_reg == '0) || dot_reg[SW-1];
    // projection beyond the end point
    assign near_end   = dot_reg > $signed(SW'(len_reg));

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            crm_reg  <= cross_reg[SW-1] ? CM'(-cross_reg) : CM'(cross_reg);
            sq_reg   <= near_start ? sqa_reg : sqb_reg;
            lend_reg <= len_reg;
            perp_reg <= !near_start && !near_end;
        end
    end

    // ---------------- squared cross product ----------------
    logic [NW-1:0] cr_sq;
    logic [LW-1:0] sq_dly_reg  [ML];
    logic [LW-1:0] len_dly_reg [ML];
    logic          perp_dly_reg[ML];
    logic          ve_dly_reg  [ML];

    psd_mul #(.WIDTH(CM)) u_mul_cross (.clk, .en, .a(crm_reg), .b(crm_reg), .p(cr_sq));

    generate
        for (k = 0; k < ML; k++)
        begin : g_cdly
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    sq_dly_reg[k]   <= (k == 0) ? sq_reg   : sq_dly_reg[(k == 0) ? 0 : k-1];
                    len_dly_reg[k]  <= (k == 0) ? lend_reg : len_dly_reg[(k == 0) ? 0 : k-1];
                    perp_dly_reg[k] <= (k == 0) ? perp_reg : perp_dly_reg[(k == 0) ? 0 : k-1];
                end
            end
            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    ve_dly_reg[k] <= 1'b0;
                end
                else if (en)
                begin
                    ve_dly_reg[k] <= (k == 0) ? vd_reg : ve_dly_reg[(k == 0) ? 0 : k-1];
                end
            end
        end
    endgenerate

    // ---------------- stage e: ratio operands ----------------
    // perpendicular case: cross^2 / len, otherwise endpoint distance squared / 1
    logic [NW-1:0] num_reg;
    logic [LW-1:0] den_reg;
    logic          ve_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            num_reg <= perp_dly_reg[ML-1] ? cr_sq : NW'(sq_dly_reg[ML-1]);
            den_reg <= perp_dly_reg[ML-1] ? len_dly_reg[ML-1] : LW'(1);
        end
    end

    // front-end valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            va_reg <= 1'b0;
            vb_reg <= 1'b0;
            vc_reg <= 1'b0;
            vd_reg <= 1'b0;
            ve_reg <= 1'b0;
        end
        else if (en)
        begin
            va_reg <= in_ch.valid;
            vb_reg <= va_reg;
            vc_reg <= vm_reg[ML-1];
            vd_reg <= vc_reg;
            ve_reg <= ve_dly_reg[ML-1];
        end
    end

    // ---------------- divide and root ----------------
    logic            fin_valid;
    logic [OUTW-1:0] fin_root;

    psd_divsqrt #(
        .NW  (NW),
        .LW  (LW),
        .QW  (QW),
        .OUTW(OUTW)
    ) u_divsqrt (
        .clk,
        .rst_n,
        .en,
        .in_valid (ve_reg),
        .num      (num_reg),
        .den      (den_reg),
        .out_valid(fin_valid),
        .root     (fin_root)
    );

    // ---------------- output register with skid ----------------
    logic            out_valid_reg;
    logic [OUTW-1:0] out_data_reg;
    logic [OUTW-1:0] skid_data_reg;
    logic            arrive;

    assign arrive = en && fin_valid;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            priority if (skid_valid_reg)
            begin
                if (out_ch.ready)
                begin
                    skid_valid_reg <= 1'b0;
                end
            end
            else if (arrive)
            begin
                if (out_valid_reg && !out_ch.ready)
                begin
                    skid_valid_reg <= 1'b1;
                end
                else
                begin
                    out_valid_reg <= 1'b1;
                end
            end
            else
            begin
                if (out_ch.ready)
                begin
                    out_valid_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        priority if (skid_valid_reg)
        begin
            if (out_ch.ready)
            begin
                out_data_reg <= skid_data_reg;
            end
        end
        else
        begin
            if (arrive)
            begin
                if (out_valid_reg && !out_ch.ready)
                begin
                    skid_data_reg <= fin_root;
                end
                else
                begin
                    out_data_reg <= fin_root;
                end
            end
        end
    end

    assign out_ch.valid    = out_valid_reg;
    assign out_ch.distance = out_data_reg;
endmodule

[src/psd_mul.sv]
// ----------------------------------------------------------------------------
// psd_mul
// unsigned multiplier split into four half-width partial products, two stages
// ----------------------------------------------------------------------------
module psd_mul #(
    parameter int WIDTH = 33
) (
    input  logic               clk,
    input  logic               en,
    input  logic [WIDTH-1:0]   a,
    input  logic [WIDTH-1:0]   b,
    output logic [2*WIDTH-1:0] p
);
    localparam int H  = (WIDTH + 1) / 2;
    localparam int PW = 4 * H;

    logic [2*H-1:0] a_ext;
    logic [2*H-1:0] b_ext;
    logic [2*H-1:0] ll_reg, lh_reg, hl_reg, hh_reg;
    logic [PW-1:0]  sum_next;
    logic [2*WIDTH-1:0] p_reg;

    assign a_ext = (2*H)'(a);
    assign b_ext = (2*H)'(b);

    // stage 1: partial products
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ll_reg <= a_ext[H-1:0] * b_ext[H-1:0];
            lh_reg <= a_ext[H-1:0] * b_ext[2*H-1:H];
            hl_reg <= a_ext[2*H-1:H] * b_ext[H-1:0];
            hh_reg <= a_ext[2*H-1:H] * b_ext[2*H-1:H];
        end
    end

    // stage 2: recombine
    assign sum_next = {hh_reg, ll_reg}
                    + ({{H{1'b0}}, lh_reg, {H{1'b0}}})
                    + ({{H{1'b0}}, hl_reg, {H{1'b0}}});

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p_reg <= sum_next[2*WIDTH-1:0];
        end
    end

    assign p = p_reg;
endmodule

[src/psd_divsqrt.sv]
// ----------------------------------------------------------------------------
// psd_divsqrt
// pipelined restoring divide followed by pipelined digit-by-digit square root
// ----------------------------------------------------------------------------
module psd_divsqrt #(
    parameter int NW   = 134,
    parameter int LW   = 67,
    parameter int QW   = 66,
    parameter int OUTW = 33
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            en,
    input  logic            in_valid,
    input  logic [NW-1:0]   num,
    input  logic [LW-1:0]   den,
    output logic            out_valid,
    output logic [OUTW-1:0] root
);
    localparam int RW = OUTW + 3;

    // divider stages
    logic [LW:0]   rem_reg [QW+1];
    logic [QW-1:0] lo_reg  [QW+1];
    logic [LW-1:0] den_reg [QW+1];
    logic          dv_reg  [QW+1];

    // square root stages
    logic [OUTW:0]   srem_reg [OUTW+1];
    logic [OUTW-1:0] root_reg [OUTW+1];
    logic [QW-1:0]   rest_reg [OUTW+1];
    logic            sv_reg   [OUTW+1];

    assign rem_reg[0] = num[NW-1:QW];
    assign lo_reg[0]  = num[QW-1:0];
    assign den_reg[0] = den;
    assign dv_reg[0]  = in_valid;

    genvar i;
    generate
        for (i = 0; i < QW; i++)
        begin : g_div
            logic [LW+1:0] r2;
            logic [LW+1:0] d2;
            logic          ge;
            logic [LW+1:0] diff;

            assign r2   = {rem_reg[i], lo_reg[i][QW-1]};
            assign d2   = {2'b00, den_reg[i]};
            assign ge   = r2 >= d2;
            assign diff = r2 - d2;

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    rem_reg[i+1] <= ge ? diff[LW:0] : r2[LW:0];
                    lo_reg[i+1]  <= {lo_reg[i][QW-2:0], ge};
                    den_reg[i+1] <= den_reg[i];
                end
            end

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    dv_reg[i+1] <= 1'b0;
                end
                else if (en)
                begin
                    dv_reg[i+1] <= dv_reg[i];
                end
            end
        end

        assign srem_reg[0] = '0;
        assign root_reg[0] = '0;
        assign rest_reg[0] = lo_reg[QW];
        assign sv_reg[0]   = dv_reg[QW];

        for (i = 0; i < OUTW; i++)
        begin : g_sqrt
            logic [RW-1:0] r2;
            logic [RW-1:0] trial;
            logic          ge;
            logic [RW-1:0] diff;

            assign r2    = {srem_reg[i], rest_reg[i][QW-1:QW-2]};
            assign trial = {1'b0, root_reg[i], 2'b01};
            assign ge    = r2 >= trial;
            assign diff  = r2 - trial;

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    srem_reg[i+1] <= ge ? diff[OUTW:0] : r2[OUTW:0];
                    root_reg[i+1] <= {root_reg[i][OUTW-2:0], ge};
                    rest_reg[i+1] <= {rest_reg[i][QW-3:0], 2'b00};
                end
            end

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    sv_reg[i+1] <= 1'b0;
                end
                else if (en)
                begin
                    sv_reg[i+1] <= sv_reg[i];
                end
            end
        end
    endgenerate

    assign out_valid = sv_reg[OUTW];
    assign root      = root_reg[OUTW];
endmodule

[test/tb_psd_pkg.sv]
// ----------------------------------------------------------------------------
// tb_psd_pkg
// shared testbench settings for the point to segment distance regression
// ----------------------------------------------------------------------------
package tb_psd_pkg;

    localparam int COORD_W = 32;
    localparam int DIST_W  = COORD_W + 1;

    // kinds of directed rows
    typedef enum logic [1:0] {
        ROW_PREDICT,
        ROW_TYPED
    } row_kind_t;

endpackage

[test/tb_psd_channels.sv]
// ----------------------------------------------------------------------------
// tb_psd_channels
// query record shared by stimulus and distance predictor
// ----------------------------------------------------------------------------
package tb_psd_channels;

    typedef struct packed {
        logic signed [31:0] px;
        logic signed [31:0] py;
        logic signed [31:0] sx;
        logic signed [31:0] sy;
        logic signed [31:0] ex;
        logic signed [31:0] ey;
    } query_t;

endpackage

[test/tb_point_segment_distance.sv]
// ----------------------------------------------------------------------------
// tb_point_segment_distance
// checks exact floored point to segment distance against a local predictor
// ----------------------------------------------------------------------------
// directed rows cover the extremes and each projection region, then random
// queries run under four idling profiles; one phase holds the result side
// off for a long stretch so that the skid register fills and stalls the intake
// ----------------------------------------------------------------------------
module tb_point_segment_distance;

    localparam int  DIR_ROWS   = 16;
    localparam int  RAND_ITEMS = 640;
    localparam int  HOLD_CYCLES = 300;
    localparam longint CYCLE_LIMIT = 400000;

    typedef struct {
        tb_psd_pkg::row_kind_t    kind;
        tb_psd_channels::query_t  q;
        logic [32:0]              want_dist;
    } dir_row_t;

    logic clk;
    logic rst_n;

    psd_in_if  #(.COORD_WIDTH(tb_psd_pkg::COORD_W)) in_ch ();
    psd_out_if #(.COORD_WIDTH(tb_psd_pkg::COORD_W)) out_ch ();

    point_segment_distance #(.COORD_WIDTH(tb_psd_pkg::COORD_W)) u_top (
        .clk   (clk),
        .rst_n (rst_n),
        .in_ch (in_ch.sink),
        .out_ch(out_ch.source)
    );

    // expected distances in transaction order
    logic [32:0] dist_queue[$];
    int          mismatches;
    longint      cycles;
    int          send_idle_pct;
    int          recv_idle_pct;
    bit          hold_active = 1'b0;
    dir_row_t    dir_rows[DIR_ROWS];

    // ------------------------------------------------------------------
    // predictor: exact floor(sqrt(num/den)) with wide integers
    // ------------------------------------------------------------------
    function automatic logic [32:0] segment_distance(tb_psd_channels::query_t q);
        logic signed [33:0]  ax, ay, cx, cy, fx, fy;
        logic signed [135:0] dot, len, crs, num, den;
        logic [135:0]        trial_sq;
        logic [32:0]         root;
        logic [32:0]         trial;
        ax = 34'(q.px) - 34'(q.sx);
        ay = 34'(q.py) - 34'(q.sy);
        cx = 34'(q.ex) - 34'(q.sx);
        cy = 34'(q.ey) - 34'(q.sy);
        fx = 34'(q.px) - 34'(q.ex);
        fy = 34'(q.py) - 34'(q.ey);
        dot = 136'(ax) * 136'(cx) + 136'(ay) * 136'(cy);
        len = 136'(cx) * 136'(cx) + 136'(cy) * 136'(cy);
        if (len == 0 || dot < 0)
        begin
            // before the start, or degenerate segment
            num = 136'(ax) * 136'(ax) + 136'(ay) * 136'(ay);
            den = 1;
        end
        else if (dot > len)
        begin
            // past the end
            num = 136'(fx) * 136'(fx) + 136'(fy) * 136'(fy);
            den = 1;
        end
        else
        begin
            // perpendicular foot: cross^2 / len
            crs = 136'(ax) * 136'(cy) - 136'(ay) * 136'(cx);
            num = crs * crs;
            den = len;
        end
        root = '0;
        for (int b = tb_psd_pkg::DIST_W - 1; b >= 0; b--)
        begin
            trial = root | (33'd1 << b);
            trial_sq = 136'(trial) * 136'(trial);
            if ($unsigned(trial_sq * $unsigned(den)) <= $unsigned(num))
                root = trial;
        end
        return root;
    endfunction

    function automatic tb_psd_channels::query_t make_query(int px, int py, int sx, int sy,
                                                           int ex, int ey);
        tb_psd_channels::query_t q;
        q.px = px; q.py = py; q.sx = sx; q.sy = sy; q.ex = ex; q.ey = ey;
        return q;
    endfunction

    function automatic logic signed [31:0] rand_coord(int span_sel);
        logic signed [31:0] v;
        case (span_sel)
            0: v = $urandom_range(0, 4096) - 2048;
            1: v = $urandom_range(0, 32'h0020_0000) - 32'h0010_0000;
            2: v = $urandom_range(0, 1) ? 32'h7fff_ffff - $urandom_range(0, 15)
                                        : 32'h8000_0000 + $urandom_range(0, 15);
            default: v = $urandom;
        endcase
        return v;
    endfunction

    // ------------------------------------------------------------------
    // clock and cycle limit
    // ------------------------------------------------------------------
    initial
    begin
        clk = 1'b0;
        forever
            #6 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("point_segment_distance regression: fail");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // result side: random stall, long hold-off, compare with the oldest
    // ------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ch.ready <= 1'b0;
        end
        else
        begin
            if (out_ch.valid && out_ch.ready)
            begin
                if (dist_queue.size() == 0)
                begin
                    $error("distance: no expectation waiting, actual %0d", out_ch.distance);
                    mismatches++;
                end
                else
                begin
                    logic [32:0] want;
                    want = dist_queue.pop_front();
                    if (out_ch.distance !== want)
                    begin
                        $error("distance: expected %0d actual %0d", want, out_ch.distance);
                        mismatches++;
                    end
                end
            end
            if (hold_active)
                out_ch.ready <= 1'b0;
            else
                out_ch.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    // ------------------------------------------------------------------
    // query side
    // ------------------------------------------------------------------
    task automatic send_query(tb_psd_channels::query_t q, bit typed_row = 1'b0,
                              logic [32:0] typed_dist = '0);
        logic [32:0] expected;
        expected = typed_row ? typed_dist : segment_distance(q);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            in_ch.valid <= 1'b0;
            @(posedge clk);
        end
        in_ch.valid   <= 1'b1;
        in_ch.point_x <= q.px;
        in_ch.point_y <= q.py;
        in_ch.start_x <= q.sx;
        in_ch.start_y <= q.sy;
        in_ch.end_x   <= q.ex;
        in_ch.end_y   <= q.ey;
        do
            @(posedge clk);
        while (!in_ch.ready);
        dist_queue = {dist_queue, expected};
    endtask

    task automatic send_random(int count);
        tb_psd_channels::query_t q;
        int     span;
        for (int i = 0; i < count; i++)
        begin
            span = $urandom_range(0, 3);
            q.px = rand_coord(span); q.py = rand_coord(span);
            q.sx = rand_coord(span); q.sy = rand_coord(span);
            // some segments collapse to a point
            if ($urandom_range(0, 15) == 0)
            begin
                q.ex = q.sx; q.ey = q.sy;
            end
            else
            begin
                q.ex = rand_coord(span); q.ey = rand_coord(span);
            end
            send_query(q);
        end
    endtask

    initial
    begin
        mismatches    = 0;
        cycles        = 0;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        rst_n         = 1'b0;
        in_ch.valid   = 1'b0;
        in_ch.point_x = '0; in_ch.point_y = '0;
        in_ch.start_x = '0; in_ch.start_y = '0;
        in_ch.end_x   = '0; in_ch.end_y   = '0;

        // directed table: typed rows are trivially readable
        dir_rows[0]  = '{tb_psd_pkg::ROW_TYPED,   make_query(0, 0, 0, 0, 0, 0), 33'd0};
        dir_rows[1]  = '{tb_psd_pkg::ROW_TYPED,   make_query(3, 4, 0, 0, 0, 0), 33'd5};
        dir_rows[2]  = '{tb_psd_pkg::ROW_TYPED,   make_query(-5, 0, 0, 0, 10, 0), 33'd5};
        dir_rows[3]  = '{tb_psd_pkg::ROW_TYPED,   make_query(13, 4, 0, 0, 10, 0), 33'd5};
        dir_rows[4]  = '{tb_psd_pkg::ROW_TYPED,   make_query(5, 7, 0, 0, 10, 0), 33'd7};
        dir_rows[5]  = '{tb_psd_pkg::ROW_TYPED,   make_query(0, 9, 0, 0, 10, 0), 33'd9};
        dir_rows[6]  = '{tb_psd_pkg::ROW_TYPED,   make_query(10, -9, 0, 0, 10, 0), 33'd9};
        dir_rows[7]  = '{tb_psd_pkg::ROW_TYPED,   make_query(32'h7fffffff, 0, 32'h80000000, 0,
                                                 32'h80000000, 0), 33'h0_ffff_ffff};
        dir_rows[8]  = '{tb_psd_pkg::ROW_PREDICT, make_query(32'h7fffffff, 32'h7fffffff,
                                                 32'h80000000, 32'h80000000, 32'h80000000,
                                                 32'h80000000), 33'd0};
        dir_rows[9]  = '{tb_psd_pkg::ROW_PREDICT, make_query(32'h80000000, 32'h7fffffff,
                                                 32'h80000000, 32'h80000000, 32'h7fffffff,
                                                 32'h7fffffff), 33'd0};
        dir_rows[10] = '{tb_psd_pkg::ROW_PREDICT, make_query(32'h7fffffff, 32'h80000000,
                                                 32'h80000000, 32'h7fffffff, 32'h7fffffff,
                                                 32'h7fffffff), 33'd0};
        dir_rows[11] = '{tb_psd_pkg::ROW_PREDICT, make_query(1, 1, 0, 0, 3, 7), 33'd0};
        dir_rows[12] = '{tb_psd_pkg::ROW_PREDICT, make_query(-1, -1, -1, -1, -1, -1), 33'd0};
        dir_rows[13] = '{tb_psd_pkg::ROW_PREDICT, make_query(32'h55555555, 32'haaaaaaaa,
                                                 32'haaaaaaaa, 32'h55555555, 32'h12345678,
                                                 32'hedcba987), 33'd0};
        dir_rows[14] = '{tb_psd_pkg::ROW_PREDICT, make_query(32'h80000000, 32'h80000000,
                                                 32'h7fffffff, 32'h80000000, 32'h80000000,
                                                 32'h7fffffff), 33'd0};
        dir_rows[15] = '{tb_psd_pkg::ROW_PREDICT, make_query(7, 3, 2, 1, 2, 1), 33'd0};

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_rows[i])
        begin
            // typed rows carry their own expected value
            send_query(dir_rows[i].q, dir_rows[i].kind == tb_psd_pkg::ROW_TYPED,
                       dir_rows[i].want_dist);
        end

        // sender idles 20 in 100, receiver 74
        send_idle_pct = 20; recv_idle_pct = 74;
        send_random(RAND_ITEMS / 4);
        // long receive hold-off, counted in its own process, while queries keep coming
        send_idle_pct = 0;
        fork
            begin
                hold_active <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_active <= 1'b0;
            end
        join_none
        send_random(RAND_ITEMS / 8);
        send_idle_pct = 74; recv_idle_pct = 20;
        send_random(RAND_ITEMS / 4);
        send_idle_pct = 0; recv_idle_pct = 0;
        send_random(RAND_ITEMS - RAND_ITEMS / 4 - RAND_ITEMS / 8 - RAND_ITEMS / 4);
        in_ch.valid <= 1'b0;

        while (dist_queue.size() != 0)
            @(posedge clk);
        repeat (200) @(posedge clk);

        if (mismatches == 0 && dist_queue.size() == 0)
            $display("point_segment_distance regression: pass");
        else
            $display("point_segment_distance regression: fail");
        $finish;
    end

endmodule

[sim.f]
src/psd_pkg.sv
src/psd_in_if.sv
src/psd_out_if.sv
src/psd_mul.sv
src/psd_divsqrt.sv
src/point_segment_distance.sv
test/tb_psd_pkg.sv
test/tb_psd_channels.sv
test/tb_point_segment_distance.sv
